>>> hw/rtl/rrcs_pkg.sv
// Shared types and constants for the round robin context switcher.
package rrcs_pkg;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 2;
  localparam int THR_W  = 3;
  localparam int PORT_W = 32;
  localparam int STS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_BLOCK = 2'd2,
    OP_WAKE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ACTIVE  = 2'd0,
    ST_READY   = 2'd1,
    ST_WAITING = 2'd2
  } thread_state_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK         = 2'd0,
    STS_IDLE_BLOCK = 2'd1,
    STS_RUN_LOAD   = 2'd2
  } status_t;

endpackage

>>> hw/rtl/rrcs_state_mem.sv
// Thread state memory: one write port, one registered read port.
module rrcs_state_mem
  import rrcs_pkg::*;
#(
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  thread_state_t wdata,
  input  logic [AW-1:0] raddr,
  output thread_state_t rdata
);

  thread_state_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rrcs_ctx_mem.sv
// Saved register context memory: one row of three registers per thread.
module rrcs_ctx_mem
  import rrcs_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int WIDTH = 96,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/round_robin_context_switcher.sv
// Round robin hardware thread context switcher, top level.
// One transaction is taken at a time; its result lands in an output register, so the next
// transaction may be taken while that result waits. A load, or a block while idle, passes
// through the decode and done states before the next acceptance. A timer tick or a block
// adds the ready search, which reads the thread state memory one slot a cycle (a switch
// adds the commit and load states for the context memory save and read). A wake first
// rewrites the thread state memory one thread a cycle and searches only when every
// thread was waiting. After reset a clearing pass zeroes the contexts and marks all
// threads ready; in_ready stays low meanwhile.
module round_robin_context_switcher
  import rrcs_pkg::*;
#(
  parameter int NUM_THREADS = 4,
  parameter int REG_WIDTH   = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [IDX_W-1:0]         thread_index,
  input  logic signed [PORT_W-1:0] reg_a,
  input  logic signed [PORT_W-1:0] reg_b,
  input  logic signed [PORT_W-1:0] reg_c,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [THR_W-1:0]         running_thread,
  output logic                     switched,
  output logic signed [PORT_W-1:0] out_a,
  output logic signed [PORT_W-1:0] out_b,
  output logic signed [PORT_W-1:0] out_c,
  output logic [STS_W-1:0]         status
);

  localparam int TW    = $clog2(NUM_THREADS + 1);
  localparam int AW    = $clog2(NUM_THREADS);
  localparam int KW    = $clog2(NUM_THREADS + 2);
  localparam int ROW_W = 3 * REG_WIDTH;
  localparam logic [TW-1:0] IDLE_T   = TW'(NUM_THREADS);
  localparam logic [AW-1:0] LAST_A   = AW'(NUM_THREADS - 1);
  localparam logic [KW-1:0] LAST_K   = KW'(NUM_THREADS);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_WAKE   = 8'b0000_1000,
    S_SEARCH = 8'b0001_0000,
    S_COMMIT = 8'b0010_0000,
    S_LOAD   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } fsm_t;

  fsm_t              fsm;
  logic [TW-1:0]     cur;
  logic [TW-1:0]     wcount;
  logic [AW-1:0]     sweep;
  op_t               op_q;
  logic [TW-1:0]     idx_q;
  logic [PORT_W-1:0] la, lb, lc;
  logic              all_wait;
  logic [TW-1:0]     cand;
  logic [KW-1:0]     k;
  logic              p_valid;
  logic [TW-1:0]     p_cand;
  logic [TW-1:0]     nxt;
  logic              res_sw;
  logic [PORT_W-1:0] res_a, res_b, res_c;
  status_t           res_sts;

  logic              st_we;
  logic [AW-1:0]     st_waddr;
  thread_state_t     st_wdata;
  logic [AW-1:0]     st_raddr;
  thread_state_t     st_rdata;
  logic              ctx_we;
  logic [AW-1:0]     ctx_waddr;
  logic [ROW_W-1:0]  ctx_wdata;
  logic [AW-1:0]     ctx_raddr;
  logic [ROW_W-1:0]  ctx_rdata;

  logic [ROW_W-1:0]  live_row;
  logic              hit;
  logic              issuing;

  function automatic logic [TW-1:0] slot_after(input logic [TW-1:0] s);
    return (s == IDLE_T) ? '0 : s + 1'b1;
  endfunction

  rrcs_state_mem #(.DEPTH(NUM_THREADS)) u_state_mem (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rrcs_ctx_mem #(.DEPTH(NUM_THREADS), .WIDTH(ROW_W)) u_ctx_mem (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (ctx_waddr),
    .wdata (ctx_wdata),
    .raddr (ctx_raddr),
    .rdata (ctx_rdata)
  );

  assign live_row = {REG_WIDTH'(lc), REG_WIDTH'(lb), REG_WIDTH'(la)};
  assign hit      = p_valid && (st_rdata == ST_READY);
  assign issuing  = (k <= LAST_K);
  assign in_ready = (fsm == S_IDLE);
  assign st_raddr  = (cand == IDLE_T) ? '0 : AW'(cand);
  assign ctx_raddr = AW'(nxt);

  always_comb begin
    st_we     = 1'b0;
    st_waddr  = sweep;
    st_wdata  = ST_READY;
    ctx_we    = 1'b0;
    ctx_waddr = sweep;
    ctx_wdata = '0;
    case (fsm)
      S_INIT: begin
        st_we  = 1'b1;
        ctx_we = 1'b1;
      end
      S_WAKE: begin
        st_we    = 1'b1;
        st_wdata = (TW'(sweep) == cur) ? ST_ACTIVE : ST_READY;
      end
      S_DECODE: begin
        if (op_q == OP_LOAD && idx_q != cur && idx_q < IDLE_T) begin
          ctx_we    = 1'b1;
          ctx_waddr = AW'(idx_q);
          ctx_wdata = live_row;
        end
        if (op_q == OP_BLOCK && cur != IDLE_T) begin
          st_we    = 1'b1;
          st_waddr = AW'(cur);
          st_wdata = ST_WAITING;
        end
      end
      S_SEARCH: begin
        // go idle: keep the blocked thread's registers
        if (!hit && !issuing && op_q == OP_BLOCK) begin
          ctx_we    = 1'b1;
          ctx_waddr = AW'(cur);
          ctx_wdata = live_row;
        end
      end
      S_COMMIT: begin
        if (cur != IDLE_T) begin
          ctx_we    = 1'b1;
          ctx_waddr = AW'(cur);
          ctx_wdata = live_row;
          if (op_q == OP_TICK) begin
            st_we    = 1'b1;
            st_waddr = AW'(cur);
            st_wdata = ST_READY;
          end
        end
      end
      S_LOAD: begin
        st_we    = 1'b1;
        st_waddr = AW'(nxt);
        st_wdata = ST_ACTIVE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_INIT;
      sweep     <= '0;
      cur       <= IDLE_T;
      wcount    <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && fsm != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (fsm)
        S_INIT: begin
          if (sweep == LAST_A) begin
            sweep <= '0;
            fsm   <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= op_t'(operation);
            idx_q <= TW'(thread_index);
            la    <= reg_a;
            lb    <= reg_b;
            lc    <= reg_c;
            fsm   <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_sw  <= 1'b0;
          res_a   <= (op_q == OP_LOAD) ? '0 : la;
          res_b   <= (op_q == OP_LOAD) ? '0 : lb;
          res_c   <= (op_q == OP_LOAD) ? '0 : lc;
          p_valid <= 1'b0;
          cand    <= slot_after(cur);
          k       <= KW'(1);
          case (op_q)
            OP_LOAD: begin
              res_sts <= (idx_q == cur) ? STS_RUN_LOAD : STS_OK;
              fsm     <= S_DONE;
            end
            OP_TICK: begin
              res_sts <= STS_OK;
              fsm     <= S_SEARCH;
            end
            OP_BLOCK: begin
              if (cur == IDLE_T) begin
                res_sts <= STS_IDLE_BLOCK;
                fsm     <= S_DONE;
              end else begin
                res_sts <= STS_OK;
                wcount  <= wcount + 1'b1;
                fsm     <= S_SEARCH;
              end
            end
            OP_WAKE: begin
              res_sts  <= STS_OK;
              all_wait <= (wcount == IDLE_T);
              wcount   <= '0;
              sweep    <= '0;
              fsm      <= S_WAKE;
            end
            default: begin
              res_sts <= STS_OK;
              fsm     <= S_DONE;
            end
          endcase
        end
        S_WAKE: begin
          if (sweep == LAST_A) begin
            sweep <= '0;
            fsm   <= all_wait ? S_SEARCH : S_DONE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_SEARCH: begin
          p_valid <= issuing && (cand != IDLE_T);
          p_cand  <= cand;
          if (issuing) begin
            cand <= slot_after(cand);
            k    <= k + 1'b1;
          end
          if (hit) begin
            nxt <= p_cand;
            fsm <= S_COMMIT;
          end else if (!issuing) begin
            if (op_q == OP_BLOCK) begin
              cur <= IDLE_T;
            end
            fsm <= S_DONE;
          end
        end
        S_COMMIT: begin
          fsm <= S_LOAD;
        end
        S_LOAD: begin
          res_a  <= PORT_W'(ctx_rdata[REG_WIDTH-1:0]);
          res_b  <= PORT_W'(ctx_rdata[2*REG_WIDTH-1:REG_WIDTH]);
          res_c  <= PORT_W'(ctx_rdata[ROW_W-1:2*REG_WIDTH]);
          res_sw <= 1'b1;
          cur    <= nxt;
          fsm    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            running_thread <= THR_W'(cur);
            switched       <= res_sw;
            out_a          <= $signed(res_a);
            out_b          <= $signed(res_b);
            out_c          <= $signed(res_c);
            status         <= res_sts;
            out_valid      <= 1'b1;
            fsm            <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_INIT;
        end
      endcase
    end
  end

  a_switch_to_other: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_LOAD) |-> (nxt != cur))
    else $error("switch targets the running thread");

  a_block_counts: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_DECODE && op_q == OP_BLOCK && cur != IDLE_T) |=>
      (wcount == $past(wcount) + 1'b1))
    else $error("block did not advance the waiting count");

  a_done_presents: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_DONE && (!out_valid || out_ready)) |=> (out_valid && in_ready))
    else $error("finished transaction not presented");

endmodule
